[rtl/core/lpht_pkg.sv]
// lpht_pkg: shared types and constants of the linear probing hash table
// used by the request channel interface and by the top level; depends on nothing
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int KEY_WIDTH = 31;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_FIND   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_KEY,
      ST_HASH_SLOT,
      ST_PROBE,
      ST_RESULT
   } state_type;

endpackage

[rtl/core/lpht_req_if.sv]
// lpht_req_if: request channel (valid/ready, request code and key)
// depends on lpht_pkg for the key width
`timescale 1ns / 1ps

interface lpht_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [lpht_pkg::KEY_WIDTH-1:0]  key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

[rtl/core/lpht_rsp_if.sv]
// lpht_rsp_if: result channel (valid/ready, hit and table_full flags)
// no dependencies
`timescale 1ns / 1ps

interface lpht_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic table_full;

   modport source (output valid, output hit, output table_full, input ready);
   modport sink   (input valid, input hit, input table_full, output ready);
endinterface

[rtl/core/lpht_ram.sv]
// lpht_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/linear_probing_hash_table.sv]
// linear_probing_hash_table: top level, control, reciprocal hash and probe loop
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if and lpht_ram
`timescale 1ns / 1ps

// Open-addressing hash table with linear probing over TABLE_DEPTH slots held in
// one ram, each word a used flag and a 31-bit key. A request inserts a key
// (first empty slot from the home slot on, duplicates allowed; table_full when
// a whole sweep finds no empty slot) or finds it (hit on the key, miss on an
// empty slot or after a whole sweep). The home slot is key mod HASH_DIVISOR,
// then mod TABLE_DEPTH; each remainder takes three steps (reciprocal multiply,
// multiply back and subtract, one correcting subtract). Probing reads one slot
// per cycle through the ram read port and checks from 1 up to TABLE_DEPTH
// slots. The next request can be accepted in the cycle the result appears. The
// block takes one request at a time; a finished result waits in an output
// register while the next item is accepted, and a result that finds that
// register still occupied holds the block until the register drains.
// After reset a clearing pass writes every slot empty before the first request
// is accepted.
module linear_probing_hash_table #(
   parameter int TABLE_DEPTH  = 32,
   parameter int HASH_DIVISOR = 10
) (
   input  logic        clock,
   input  logic        reset,
   lpht_req_if.sink    req_chan,
   lpht_rsp_if.source  rsp_chan
);

   localparam int KW   = lpht_pkg::KEY_WIDTH;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int MAXD = (HASH_DIVISOR > TABLE_DEPTH) ? HASH_DIVISOR : TABLE_DEPTH;
   localparam int RW   = $clog2(MAXD) + 1;
   localparam int WW   = KW + 1;

   // truncated reciprocals: the quotient estimate is low by at most one
   localparam logic [KW:0]   KEY_RECIP  = (KW + 1)'((64'd1 << KW) / HASH_DIVISOR);
   localparam logic [RW-1:0] SLOT_RECIP = RW'((1 << RW) / TABLE_DEPTH);

   lpht_pkg::state_type state_ff, state_in;

   logic [KW-1:0]   key_ff, key_in;
   logic            find_ff, find_in;
   logic [KW-1:0]   src_ff, src_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [1:0]      step_ff, step_in;
   logic [AW-1:0]   issue_idx_ff, issue_idx_in;
   logic [AW-1:0]   chk_idx_ff, chk_idx_in;
   logic [CW-1:0]   issue_cnt_ff, issue_cnt_in;
   logic [CW-1:0]   chk_cnt_ff, chk_cnt_in;
   logic            rd_pend_ff, rd_pend_in;
   logic [AW-1:0]   clr_idx_ff, clr_idx_in;
   logic            hit_res_ff, hit_res_in;
   logic            full_res_ff, full_res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_hit_ff, rsp_hit_in;
   logic            rsp_full_ff, rsp_full_in;

   // hash step
   logic [2*KW-1:0] key_prod;
   logic [KW-1:0]   key_quot;
   logic [RW-1:0]   key_rem_est;
   logic [2*RW-1:0] slot_prod;
   logic [RW-1:0]   slot_quot;
   logic [RW-1:0]   slot_rem_est;
   logic [RW-1:0]   div_sel;
   logic [RW-1:0]   rem_fix;
   logic            hash_last;

   // probe
   logic            slot_used;
   logic            key_match;
   logic            chk_last;
   logic            probe_done;
   logic            issuing;
   logic            req_fire;
   logic            rsp_load;
   logic            clr_last;

   // ram ports
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [WW-1:0]   wr_data;
   logic [WW-1:0]   rd_data;

   lpht_ram #(
      .WIDTH (WW),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issuing),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   // remainder by multiply with the reciprocal, multiply back, subtract, then correct once
   assign key_prod     = (2 * KW)'(key_ff) * (2 * KW)'(KEY_RECIP);
   assign key_quot     = key_prod[2*KW-1:KW];
   assign key_rem_est  = key_ff[RW-1:0] - RW'(src_ff * KW'(HASH_DIVISOR));
   assign slot_prod    = (2 * RW)'(rem_ff) * (2 * RW)'(SLOT_RECIP);
   assign slot_quot    = slot_prod[2*RW-1:RW];
   assign slot_rem_est = rem_ff - RW'(src_ff * KW'(TABLE_DEPTH));
   assign div_sel      = (state_ff == lpht_pkg::ST_HASH_KEY) ?
                         RW'(HASH_DIVISOR) : RW'(TABLE_DEPTH);
   assign rem_fix      = (rem_ff >= div_sel) ? (rem_ff - div_sel) : rem_ff;
   assign hash_last    = (step_ff == 2'd2);

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == lpht_pkg::ST_RESULT) && (!rsp_valid_ff || rsp_chan.ready);
   assign clr_last = (clr_idx_ff == AW'(TABLE_DEPTH - 1));

   assign issuing   = (state_ff == lpht_pkg::ST_PROBE) && (issue_cnt_ff != CW'(TABLE_DEPTH));
   assign slot_used = rd_data[WW-1];
   assign key_match = (rd_data[KW-1:0] == key_ff);
   assign chk_last  = (chk_cnt_ff == CW'(TABLE_DEPTH - 1));
   assign probe_done = (state_ff == lpht_pkg::ST_PROBE) && rd_pend_ff &&
                       (!slot_used || chk_last ||
                        ((find_ff == lpht_pkg::REQ_FIND) && key_match));

   assign req_chan.ready      = (state_ff == lpht_pkg::ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.table_full = rsp_full_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            if (clr_last) state_in = lpht_pkg::ST_IDLE;
         end
         lpht_pkg::ST_IDLE: begin
            if (req_fire) state_in = lpht_pkg::ST_HASH_KEY;
         end
         lpht_pkg::ST_HASH_KEY: begin
            if (hash_last) state_in = lpht_pkg::ST_HASH_SLOT;
         end
         lpht_pkg::ST_HASH_SLOT: begin
            if (hash_last) state_in = lpht_pkg::ST_PROBE;
         end
         lpht_pkg::ST_PROBE: begin
            if (probe_done) state_in = lpht_pkg::ST_RESULT;
         end
         lpht_pkg::ST_RESULT: begin
            if (rsp_load) state_in = lpht_pkg::ST_IDLE;
         end
         default: state_in = lpht_pkg::ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      key_in       = key_ff;
      find_in      = find_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      issue_idx_in = issue_idx_ff;
      chk_idx_in   = chk_idx_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_cnt_in   = chk_cnt_ff;
      rd_pend_in   = 1'b0;
      clr_idx_in   = clr_idx_ff;
      hit_res_in   = hit_res_ff;
      full_res_in  = full_res_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = {1'b1, key_ff};

      case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         lpht_pkg::ST_IDLE: begin
            if (req_fire) begin
               key_in  = req_chan.key;
               find_in = req_chan.req_type;
               src_in  = req_chan.key;
               rem_in  = '0;
               step_in = '0;
            end
         end
         lpht_pkg::ST_HASH_KEY: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: src_in = key_quot;
               2'd1: rem_in = key_rem_est;
               default: begin
                  // key mod divisor, folded into the slot range next
                  rem_in  = rem_fix;
                  step_in = '0;
               end
            endcase
         end
         lpht_pkg::ST_HASH_SLOT: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: src_in = KW'(slot_quot);
               2'd1: rem_in = slot_rem_est;
               default: begin
                  step_in      = '0;
                  issue_idx_in = rem_fix[AW-1:0];
                  issue_cnt_in = '0;
                  chk_cnt_in   = '0;
               end
            endcase
         end
         lpht_pkg::ST_PROBE: begin
            // reads run one slot ahead of the check; extra reads after the end are dropped
            if (issuing) begin
               rd_pend_in   = 1'b1;
               chk_idx_in   = issue_idx_ff;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               issue_idx_in = (issue_idx_ff == AW'(TABLE_DEPTH - 1)) ? '0 : issue_idx_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
            end
            if (probe_done) begin
               rd_pend_in = 1'b0;
               if (find_ff == lpht_pkg::REQ_FIND) begin
                  hit_res_in  = slot_used && key_match;
                  full_res_in = 1'b0;
               end else begin
                  hit_res_in  = 1'b0;
                  full_res_in = slot_used;
                  wr_en       = !slot_used;
               end
            end
         end
         lpht_pkg::ST_RESULT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_res_ff;
               rsp_full_in  = full_res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         step_ff      <= '0;
         issue_cnt_ff <= '0;
         chk_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         step_ff      <= step_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_cnt_ff   <= chk_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      find_ff      <= find_in;
      src_ff       <= src_in;
      rem_ff       <= rem_in;
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff   <= chk_idx_in;
      hit_res_ff   <= hit_res_in;
      full_res_ff  <= full_res_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule

[verif/linear_probing_hash_table_test.sv]
// linear_probing_hash_table_test: self-checking bench for the linear probing hash table
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if and linear_probing_hash_table
`timescale 1ns / 1ps

module linear_probing_hash_table_test;

   localparam int KEY_WIDTH    = lpht_pkg::KEY_WIDTH;
   localparam int TABLE_DEPTH  = 32;
   localparam int HASH_DIVISOR = 10;
   localparam logic [KEY_WIDTH-1:0] KEY_MAX = 31'h7FFF_FFFF;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic hit;
      logic table_full;
   } lookup_flags_type;

   // mirror of the slot store, predicts the flags of every accepted request
   class slot_table_tracker;
      int                   depth;
      int                   divisor;
      bit                   slot_used[];
      bit [KEY_WIDTH-1:0]   slot_key[];
      bit [KEY_WIDTH-1:0]   stored_keys[$];
      lookup_flags_type     expected_flags[$];
      int                   fill;
      int                   errors;

      function new(int d, int h);
         depth = d;
         divisor = h;
         slot_used = new[d];
         slot_key = new[d];
         fill = 0;
         errors = 0;
      endfunction

      function void note_request(logic kind, logic [KEY_WIDTH-1:0] key);
         lookup_flags_type want;
         int unsigned      idx;
         int               p;
         want = '0;
         idx = (32'(key) % 32'(divisor)) % 32'(depth);
         if (kind == lpht_pkg::REQ_FIND) begin
            for (p = 0; p < depth; p++) begin
               if (!slot_used[idx])
                  break;
               if (slot_key[idx] == key) begin
                  want.hit = 1'b1;
                  break;
               end
               idx = (idx + 1 == depth) ? 0 : idx + 1;
            end
         end else begin
            want.table_full = 1'b1;
            for (p = 0; p < depth; p++) begin
               if (!slot_used[idx]) begin
                  slot_used[idx] = 1'b1;
                  slot_key[idx] = key;
                  stored_keys = {stored_keys, key};
                  fill++;
                  want.table_full = 1'b0;
                  break;
               end
               idx = (idx + 1 == depth) ? 0 : idx + 1;
            end
         end
         expected_flags = {expected_flags, want};
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic hit, logic table_full);
         lookup_flags_type want;
         if (expected_flags.size() == 0) begin
            report_mismatch($sformatf("unexpected item hit=%b table_full=%b", hit, table_full));
            return;
         end
         want = expected_flags.pop_front();
         if (hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
         if (table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, want %b", table_full, want.table_full));
      endtask

      task check_drained();
         if (expected_flags.size() != 0)
            report_mismatch($sformatf("%0d items never came out", expected_flags.size()));
      endtask
   endclass

   logic clock;
   logic reset;
   slot_table_tracker board;
   bit   calm_phase;
   bit   hold_done;
   int   results_seen;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probing_hash_table #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .HASH_DIVISOR (HASH_DIVISOR)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: compare every accepted item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_result(rsp_bus.hit, rsp_bus.table_full);
         results_seen++;
      end
   end

   // result side back-pressure: random stall bursts plus one long hold-off
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task send_request(logic kind, logic [KEY_WIDTH-1:0] key);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.key <= key;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      board.note_request(kind, key);
   endtask

   function logic [KEY_WIDTH-1:0] pick_stored_key();
      if (board.stored_keys.size() == 0)
         return KEY_WIDTH'($urandom);
      return board.stored_keys[$urandom_range(0, board.stored_keys.size() - 1)];
   endfunction

   function logic [KEY_WIDTH-1:0] pick_insert_key();
      case ($urandom_range(0, 9))
         0, 1, 2: return pick_stored_key();
         3, 4, 5: return KEY_WIDTH'($urandom_range(0, 99));
         6:       return KEY_MAX - KEY_WIDTH'($urandom_range(0, 20));
         default: return KEY_WIDTH'($urandom);
      endcase
   endfunction

   function logic [KEY_WIDTH-1:0] pick_find_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return pick_stored_key();
         // same home slot as a stored key, forces a walk through the cluster
         5, 6:          return pick_stored_key() + KEY_WIDTH'(10 * $urandom_range(1, 5));
         7:             return KEY_WIDTH'($urandom_range(0, 99));
         default:       return KEY_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      logic kind;
      clock = 1'b0;
      reset = 1'b1;
      calm_phase = 1'b0;
      hold_done = 1'b0;
      results_seen = 0;
      req_bus.valid = 1'b0;
      req_bus.req_type = lpht_pkg::REQ_INSERT;
      req_bus.key = '0;
      rsp_bus.ready = 1'b0;
      board = new(TABLE_DEPTH, HASH_DIVISOR);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, collisions, duplicates, extremes, walks past the divisor range
      send_request(lpht_pkg::REQ_FIND,   '0);
      send_request(lpht_pkg::REQ_INSERT, '0);
      send_request(lpht_pkg::REQ_INSERT, KEY_MAX);
      send_request(lpht_pkg::REQ_INSERT, 31'd10);
      send_request(lpht_pkg::REQ_INSERT, '0);
      send_request(lpht_pkg::REQ_FIND,   '0);
      send_request(lpht_pkg::REQ_FIND,   31'd10);
      send_request(lpht_pkg::REQ_FIND,   31'd20);
      send_request(lpht_pkg::REQ_FIND,   KEY_MAX);
      send_request(lpht_pkg::REQ_FIND,   KEY_MAX - 31'd10);
      send_request(lpht_pkg::REQ_INSERT, 31'h5555_5555);
      send_request(lpht_pkg::REQ_INSERT, 31'h2AAA_AAAA);
      send_request(lpht_pkg::REQ_FIND,   31'h2AAA_AAAA);
      send_request(lpht_pkg::REQ_FIND,   31'h5555_5555);
      send_request(lpht_pkg::REQ_INSERT, 31'd9);
      send_request(lpht_pkg::REQ_INSERT, 31'd19);
      send_request(lpht_pkg::REQ_INSERT, 31'd29);
      send_request(lpht_pkg::REQ_FIND,   31'd29);
      send_request(lpht_pkg::REQ_FIND,   31'd39);
      send_request(lpht_pkg::REQ_INSERT, 31'd1);
      send_request(lpht_pkg::REQ_FIND,   31'd1);
      send_request(lpht_pkg::REQ_FIND,   31'd5);

      // random: inserts stay rare so the table fills slowly, then full-table traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS * 85 / 100)
            calm_phase = 1'b1;
         if (board.fill < TABLE_DEPTH)
            kind = ($urandom_range(0, 24) == 0) ? lpht_pkg::REQ_INSERT : lpht_pkg::REQ_FIND;
         else
            kind = ($urandom_range(0, 4) == 0) ? lpht_pkg::REQ_INSERT : lpht_pkg::REQ_FIND;
         send_request(kind,
                      (kind == lpht_pkg::REQ_INSERT) ? pick_insert_key() : pick_find_key());
      end
      req_bus.valid <= 1'b0;

      while (board.expected_flags.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      board.check_drained();
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[linear_probing_hash_table.f]
rtl/core/lpht_pkg.sv
rtl/core/lpht_req_if.sv
rtl/core/lpht_rsp_if.sv
rtl/core/lpht_ram.sv
rtl/core/linear_probing_hash_table.sv
verif/linear_probing_hash_table_test.sv
